/* rtl/pcrl_pkg.sv */
// ----------------------------------------------------------------------------
// pcrl_pkg
// Shared constants, status codes and record types for the per-client
// fixed-window rate limiter.
// ----------------------------------------------------------------------------
package pcrl_pkg;

	// Table geometry
	localparam int CLIENT_SLOTS = 32;

	// Field widths
	localparam int PEER_W  = 32;
	localparam int TIME_W  = 64;
	localparam int COUNT_W = 10;
	localparam int STAT_W  = 3;

	// Window length in ms
	localparam logic [TIME_W-1:0] WINDOW_MS = TIME_W'(1000);

	// Stream payload widths
	localparam int IN_DATA_W  = PEER_W + TIME_W;                   // 96
	localparam int OUT_USED_W = STAT_W + COUNT_W;                  // 13
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;        // 16

	// Item kinds
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RETIRE  = 1'b1;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_ACCEPTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_LIMITED  = 3'd2,
		ST_INVALID  = 3'd3,
		ST_RETIRED  = 3'd4,
		ST_IGNORED  = 3'd5
	} status_t;

	// One client record
	typedef struct packed {
		logic [PEER_W-1:0]  peer;
		logic [TIME_W-1:0]  start;
		logic [COUNT_W-1:0] count;
	} rec_t;

	// Lookup flags handed along the row of cells
	typedef struct packed {
		logic free_seen;  // a free record lies at a lower index
		logic any_hit;    // some cell holds the looked-up peer
	} chain_t;

endpackage

/* rtl/pcrl_cell.sv */
// ----------------------------------------------------------------------------
// pcrl_cell
// One client record: compares against the broadcast peer, takes part in the
// first-free chain, and is rewritten when selected.
// ----------------------------------------------------------------------------
module pcrl_cell import pcrl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmp_en,
	input  logic [PEER_W-1:0] cmp_peer,
	input  chain_t            chain_in,
	output chain_t            chain_out,
	output logic              hit,
	output logic              sel,
	output rec_t              rec_sel,
	input  logic              wr_en,
	input  rec_t              wr_rec
);

	rec_t rec_q;
	logic hit_q;
	logic free_q;

	// Record storage and registered compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (cmp_en) begin
				hit_q  <= (rec_q.peer == cmp_peer);
				free_q <= (rec_q.peer == '0);
			end
			if (wr_en) begin
				rec_q <= wr_rec;
			end
		end
	end

	// Matching record wins; else the lowest free record claims the item
	assign sel = hit_q | (~chain_in.any_hit & free_q & ~chain_in.free_seen);

	assign chain_out.free_seen = chain_in.free_seen | free_q;
	assign chain_out.any_hit   = chain_in.any_hit;

	assign hit     = hit_q;
	assign rec_sel = sel ? rec_q : '0;

endmodule

/* rtl/per_client_fixed_window_rate_limiter_core.sv */
// ----------------------------------------------------------------------------
// per_client_fixed_window_rate_limiter_core
// Per-client fixed-window rate limiter over a row of client record cells.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata: peer, now_ms; tuser: op
// m_axis    out  m_axis_tvalid/tready    tdata: status, window_count
// cfg       in   cfg_we                  cfg_wdata: requests_per_window
//
// Each item passes through compare in all cells at accept, first-free
// chain and record select, then window check and write-back.
// The 64-bit window compare and the record select set the step length.
// A new item is taken while a finished result still waits in m_axis.
// A stalled m_axis holds the update step until the result register frees.
// Reset clears every record, so all slots start free; limit resets to 32.
// ----------------------------------------------------------------------------
module per_client_fixed_window_rate_limiter_core import pcrl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input items
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] peer, [95:32] now_ms
	input  logic                  s_axis_tuser,   // [0] op
	// Result items
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [2:0] status, [12:3] window_count
	// Limit register
	input  logic                  cfg_we,
	input  logic [COUNT_W-1:0]    cfg_wdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEL,
		S_UPD
	} state_t;

	state_t                  state_q;
	logic                    op_q;
	logic [PEER_W-1:0]       peer_q;
	logic [TIME_W-1:0]       now_q;
	logic [COUNT_W-1:0]      limit_q;
	logic [CLIENT_SLOTS-1:0] sel_q;
	logic                    found_q;
	logic                    hit_any_q;
	rec_t                    rec_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [COUNT_W-1:0]      out_count_q;

	logic                    in_acc;
	logic                    upd_go;
	logic [CLIENT_SLOTS-1:0] hit_vec;
	logic [CLIENT_SLOTS-1:0] sel_vec;
	rec_t                    rec_vec [CLIENT_SLOTS];
	chain_t                  chain [CLIENT_SLOTS+1];
	rec_t                    rec_mux;
	logic                    any_hit;

	// Update step results
	logic                    restart;
	logic [TIME_W-1:0]       age;
	logic [TIME_W-1:0]       start_n;
	logic [COUNT_W-1:0]      cnt0;
	logic                    limited;
	logic                    do_wr;
	rec_t                    wr_rec;
	status_t                 status_n;
	logic [COUNT_W-1:0]      count_n;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign upd_go        = (state_q == S_UPD) & (~out_valid_q | m_axis_tready);

	// Hit flags gathered for the chain head
	always_comb begin
		any_hit = 1'b0;
		for (int i = 0; i < CLIENT_SLOTS; i++) begin
			any_hit = any_hit | hit_vec[i];
		end
	end

	assign chain[0].free_seen = 1'b0;
	assign chain[0].any_hit   = any_hit;

	// Row of record cells
	for (genvar g = 0; g < CLIENT_SLOTS; g++) begin : g_cell
		pcrl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmp_en    (in_acc),
			.cmp_peer  (s_axis_tdata[PEER_W-1:0]),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.hit       (hit_vec[g]),
			.sel       (sel_vec[g]),
			.rec_sel   (rec_vec[g]),
			.wr_en     (upd_go & do_wr & sel_q[g]),
			.wr_rec    (wr_rec)
		);
	end

	// Selected record, one-hot OR
	always_comb begin
		rec_mux = '0;
		for (int i = 0; i < CLIENT_SLOTS; i++) begin
			rec_mux = rec_mux | rec_vec[i];
		end
	end

	// Window check and new record
	always_comb begin
		age     = now_q - rec_q.start;
		restart = (now_q < rec_q.start) | (age >= WINDOW_MS);
		start_n = restart ? now_q : rec_q.start;
		cnt0    = restart ? '0 : rec_q.count;
		limited = (cnt0 >= limit_q);
		do_wr   = 1'b0;
		wr_rec  = '0;
		count_n = '0;
		if (peer_q == '0) begin
			status_n = ST_INVALID;
		end else if (op_q == OP_RETIRE) begin
			if (hit_any_q) begin
				status_n = ST_RETIRED;
				do_wr    = 1'b1;
			end else begin
				status_n = ST_IGNORED;
			end
		end else if (!found_q) begin
			status_n = ST_FULL;
		end else begin
			do_wr        = 1'b1;
			wr_rec.peer  = peer_q;
			wr_rec.start = start_n;
			if (limited) begin
				status_n     = ST_LIMITED;
				wr_rec.count = cnt0;
			end else begin
				status_n     = ST_ACCEPTED;
				wr_rec.count = cnt0 + COUNT_W'(1);
			end
			count_n = wr_rec.count;
		end
	end

	// Control sequence and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			limit_q      <= COUNT_W'(32);
			out_valid_q  <= 1'b0;
			out_status_q <= ST_ACCEPTED;
			out_count_q  <= '0;
			found_q      <= 1'b0;
			hit_any_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// result register loads on update, drains on handshake
			if (upd_go) begin
				out_valid_q  <= 1'b1;
				out_status_q <= status_n;
				out_count_q  <= count_n;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					found_q   <= |sel_vec;
					hit_any_q <= any_hit;
					state_q   <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= s_axis_tuser;
			peer_q <= s_axis_tdata[PEER_W-1:0];
			now_q  <= s_axis_tdata[IN_DATA_W-1:PEER_W];
		end
		if (state_q == S_SEL) begin
			sel_q <= sel_vec;
			rec_q <= rec_mux;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W-OUT_USED_W)'(0), out_count_q, out_status_q};

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-client fixed-window rate limiter core.
// A scoreboard class keeps its own copy of the client table and the limit,
// predicts status and window count for every accepted item, and compares
// each result item in order. The stimulus runs through several limit settings
// with directed corner items and pool-based random traffic. Sender gaps and
// receiver stalls vary by phase, and one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module tb_top;
	import pcrl_pkg::*;

	localparam int POOL_SIZE = 40;

	// One predicted result item
	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	// Client table predictor and in-order result checker
	class limiter_scoreboard;
		logic [PEER_W-1:0]  peer_tab  [CLIENT_SLOTS];
		logic [TIME_W-1:0]  start_tab [CLIENT_SLOTS];
		logic [COUNT_W-1:0] count_tab [CLIENT_SLOTS];
		logic [COUNT_W-1:0] limit;
		verdict_t           awaited[$];
		int                 errors;

		function new();
			int i;
			for (i = 0; i < CLIENT_SLOTS; i++) begin
				peer_tab[i]  = '0;
				start_tab[i] = '0;
				count_tab[i] = '0;
			end
			limit  = COUNT_W'(32);
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Update the table for one accepted item and queue its result
		function void note_item(logic op, logic [PEER_W-1:0] peer,
				logic [TIME_W-1:0] now_ms);
			int i;
			int hit;
			int free_slot;
			int slot;
			verdict_t v;
			hit       = -1;
			free_slot = -1;
			for (i = 0; i < CLIENT_SLOTS; i++) begin
				if (hit < 0 && peer_tab[i] == peer)
					hit = i;
				if (free_slot < 0 && peer_tab[i] == '0)
					free_slot = i;
			end
			v.count = '0;
			if (peer == '0) begin
				v.status = ST_INVALID;
			end else if (op == OP_RETIRE) begin
				if (hit >= 0) begin
					peer_tab[hit]  = '0;
					start_tab[hit] = '0;
					count_tab[hit] = '0;
					v.status = ST_RETIRED;
				end else begin
					v.status = ST_IGNORED;
				end
			end else begin
				slot = (hit >= 0) ? hit : free_slot;
				if (slot < 0) begin
					v.status = ST_FULL;
				end else begin
					// claimed slots keep their old start and count
					peer_tab[slot] = peer;
					if (now_ms < start_tab[slot] ||
							now_ms - start_tab[slot] >= WINDOW_MS) begin
						start_tab[slot] = now_ms;
						count_tab[slot] = '0;
					end
					if (count_tab[slot] >= limit) begin
						v.status = ST_LIMITED;
					end else begin
						count_tab[slot] = count_tab[slot] + 1'b1;
						v.status = ST_ACCEPTED;
					end
					v.count = count_tab[slot];
				end
			end
			awaited.push_back(v);
		endfunction

		// Compare one result item with the oldest prediction
		function void check_result(logic [STAT_W-1:0] status, logic [COUNT_W-1:0] count);
			verdict_t v;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result item, status %0d count %0d",
					$time, status, count);
				errors++;
				return;
			end
			v = awaited.pop_front();
			if (status != v.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, v.status, status);
				errors++;
			end
			if (count != v.count) begin
				$display("%0t: window_count mismatch, expected %0d actual %0d",
					$time, v.count, count);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [COUNT_W-1:0]    cfg_wdata = '0;

	limiter_scoreboard sb = new();

	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                hold_left = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic [PEER_W-1:0] peer_pool [POOL_SIZE];

	per_client_fixed_window_rate_limiter_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: long hold-off first, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[STAT_W-1:0], m_axis_tdata[STAT_W +: COUNT_W]);
	end

	// Run limit
	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Offer one item, note it at acceptance; starts and ends at a falling edge
	task automatic send_item(input logic op, input logic [PEER_W-1:0] peer,
			input logic [TIME_W-1:0] now_ms);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		s_axis_tdata  = {now_ms, peer};
		s_axis_tuser  = op;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_item(op, peer, now_ms);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Wait for all results, then let the pipeline settle
	task automatic wait_idle();
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(input logic [COUNT_W-1:0] value);
		wait_idle();
		cfg_wdata = value;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
		sb.limit  = value;
	endtask

	// Mostly small forward steps, some window rollovers, reversals and wild values
	function automatic logic [TIME_W-1:0] next_time();
		int r;
		r = $urandom_range(99);
		if (r < 78)
			clock_ms = clock_ms + $urandom_range(120);
		else if (r < 88)
			clock_ms = clock_ms + 1000 + $urandom_range(600);
		else if (r < 94) begin
			if (clock_ms > 3000)
				clock_ms = clock_ms - $urandom_range(1, 2000);
		end else if (r < 98)
			return {$urandom(), $urandom()};
		else
			return '1;
		return clock_ms;
	endfunction

	function automatic logic [PEER_W-1:0] pick_peer(input logic op);
		int r;
		r = $urandom_range(99);
		if (op == OP_RETIRE && r < 50)
			return sb.peer_tab[$urandom_range(CLIENT_SLOTS-1)];
		if (r < 90)
			return peer_pool[$urandom_range(POOL_SIZE-1)];
		if (r < 95)
			return $urandom();
		return '0;
	endfunction

	task automatic send_random(input int n);
		int k;
		logic op;
		for (k = 0; k < n; k++) begin
			op = ($urandom_range(99) < 12) ? OP_RETIRE : OP_REQUEST;
			send_item(op, pick_peer(op), next_time());
		end
	endtask

	// Stimulus
	initial begin
		int k;
		peer_pool[0] = '1;
		peer_pool[1] = PEER_W'(1);
		for (k = 2; k < POOL_SIZE; k++) begin
			do
				peer_pool[k] = $urandom();
			while (peer_pool[k] == '0);
		end

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Reset limit, no idling: directed corners
		send_item(OP_REQUEST, '0, '0);
		send_item(OP_RETIRE, '0, '1);
		send_item(OP_RETIRE, '1, '0);
		send_item(OP_REQUEST, '1, '0);              // fresh slot keeps window at 0
		send_item(OP_REQUEST, '1, TIME_W'(999));
		send_item(OP_REQUEST, '1, TIME_W'(1000));   // window rolls over
		send_item(OP_REQUEST, '1, TIME_W'(500));    // time went backwards
		send_item(OP_REQUEST, '1, '1);
		send_item(OP_REQUEST, PEER_W'(1), '1);
		send_item(OP_RETIRE, '1, '0);
		send_item(OP_RETIRE, '1, '0);               // already gone
		send_item(OP_REQUEST, 32'h8000_0000, 64'h8000_0000_0000_0000);
		clock_ms = TIME_W'(5000);
		send_random(60);

		// Limit of one, sender idles
		write_limit(COUNT_W'(1));
		send_idle_pct = 62;
		send_item(OP_REQUEST, PEER_W'(2), clock_ms);
		send_item(OP_REQUEST, PEER_W'(2), clock_ms);
		send_random(60);

		// Limit zero, receiver stalls
		write_limit('0);
		send_idle_pct  = 0;
		recv_stall_pct = 62;
		send_item(OP_REQUEST, PEER_W'(3), clock_ms);
		send_item(OP_REQUEST, PEER_W'(3), clock_ms + 2000);
		send_random(40);

		// Largest limit, both sides idle a little
		write_limit('1);
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		send_random(80);

		// Small limit; receiver holds off while the table is flooded with new peers
		write_limit(COUNT_W'(3));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		for (k = 0; k < 40; k++)
			send_item(OP_REQUEST, 32'h0001_0000 + k, clock_ms);
		send_random(60);

		// Random small limit, sender idles
		write_limit(COUNT_W'($urandom_range(1, 8)));
		send_idle_pct = 62;
		send_random(90);

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
